// File: rtl/jse_pkg.sv
`timescale 1ns / 1ps

package jse_pkg;

  localparam int unsigned MaxBytes = 8;
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  localparam logic [7:0] QuoteCh   = 8'h22;
  localparam logic [7:0] BslashCh  = 8'h5C;
  localparam logic [7:0] NlCh      = 8'h0A;
  localparam logic [7:0] CrCh      = 8'h0D;
  localparam logic [7:0] TabCh     = 8'h09;
  localparam logic [7:0] CtrlLimit = 8'h20;
  localparam logic [7:0] LetterN   = 8'h6E;
  localparam logic [7:0] LetterR   = 8'h72;
  localparam logic [7:0] LetterT   = 8'h74;
  localparam logic [7:0] LetterU   = 8'h75;
  localparam logic [7:0] DigitZero = 8'h30;
  localparam logic [7:0] HexAlpha  = 8'h57;  // 'a' - 10

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_first;
    logic       is_last;
    logic       is_empty;
  } jse_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } jse_out_t;

  // Escaped, quoted expansion of one item.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] data;
    logic [IdxW-1:0]          last_idx;
  } jse_seq_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'd0, nib};
    if (nib < 4'd10) begin
      hex_digit = DigitZero + ext;
    end else begin
      hex_digit = HexAlpha + ext;
    end
  endfunction

endpackage

// File: rtl/jse_expand.sv
`timescale 1ns / 1ps

module jse_expand (
  input  jse_pkg::jse_in_t  item,
  output jse_pkg::jse_seq_t seq
);

  logic [jse_pkg::IdxW:0] n;
  logic [7:0]             ch;

  assign ch = item.char_byte;

  always_comb begin
    seq.data = '0;
    n        = '0;
    if (item.is_empty) begin
      seq.data[0] = jse_pkg::QuoteCh;
      seq.data[1] = jse_pkg::QuoteCh;
      n = (jse_pkg::IdxW+1)'(2);
    end else begin
      if (item.is_first) begin
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::QuoteCh;
        n = n + 1'b1;
      end
      if (ch == jse_pkg::QuoteCh || ch == jse_pkg::BslashCh ||
          ch == jse_pkg::NlCh || ch == jse_pkg::CrCh || ch == jse_pkg::TabCh ||
          ch < jse_pkg::CtrlLimit) begin
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::BslashCh;
        n = n + 1'b1;
      end
      if (ch == jse_pkg::QuoteCh || ch == jse_pkg::BslashCh) begin
        seq.data[n[jse_pkg::IdxW-1:0]] = ch;
        n = n + 1'b1;
      end else if (ch == jse_pkg::NlCh) begin
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::LetterN;
        n = n + 1'b1;
      end else if (ch == jse_pkg::CrCh) begin
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::LetterR;
        n = n + 1'b1;
      end else if (ch == jse_pkg::TabCh) begin
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::LetterT;
        n = n + 1'b1;
      end else if (ch < jse_pkg::CtrlLimit) begin
        // \u00XX form
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::LetterU;
        n = n + 1'b1;
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::DigitZero;
        n = n + 1'b1;
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::DigitZero;
        n = n + 1'b1;
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::hex_digit(ch[7:4]);
        n = n + 1'b1;
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::hex_digit(ch[3:0]);
        n = n + 1'b1;
      end else begin
        seq.data[n[jse_pkg::IdxW-1:0]] = ch;
        n = n + 1'b1;
      end
      if (item.is_last) begin
        seq.data[n[jse_pkg::IdxW-1:0]] = jse_pkg::QuoteCh;
        n = n + 1'b1;
      end
    end
    seq.last_idx = jse_pkg::IdxW'(n - 1'b1);
  end

endmodule

// File: rtl/jse_serial.sv
`timescale 1ns / 1ps

module jse_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              seq_valid,
  output logic              seq_ready,
  input  jse_pkg::jse_seq_t seq,
  output logic              res_valid,
  input  logic              res_ready,
  output jse_pkg::jse_out_t res
);

  logic              hold_valid;
  jse_pkg::jse_seq_t hold;
  logic [jse_pkg::IdxW-1:0] idx;
  logic              out_free;
  logic              emit;
  logic              at_end;
  logic              load;

  assign out_free  = !res_valid || res_ready;
  assign emit      = hold_valid && out_free;
  assign at_end    = (idx == hold.last_idx);
  // hold stage frees up in the same cycle its final byte moves out
  assign seq_ready = !hold_valid || (emit && at_end);
  assign load      = seq_valid && seq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (out_free) begin
        res_valid <= hold_valid;
      end
      if (load) begin
        hold_valid <= 1'b1;
        idx        <= '0;
      end else if (emit && at_end) begin
        hold_valid <= 1'b0;
      end else if (emit) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= seq;
    end
    if (emit) begin
      res.out_byte    <= hold.data[idx];
      res.last_of_run <= at_end;
    end
  end

endmodule

// File: rtl/json_string_escaper_top.sv
`timescale 1ns / 1ps

// Channel | Handshake                | Payload
// input   | item_valid / item_ready  | item : jse_in_t  (char_byte, flags)
// output  | res_valid / res_ready    | res  : jse_out_t (out_byte, last_of_run)
//
// Each item is expanded into 1 to 8 output bytes, one byte per cycle out of the
// hold register while the output is not stalled.
// Plain bytes flow at one item per cycle while the output is not stalled; the
// first byte passes through the hold register and then the output register.
// Reset (rst, synchronous) empties the hold and output registers.
// A stalled output holds its byte; the hold stage takes a new item only when it
// is empty or as its last byte moves to the output register.

module json_string_escaper_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  jse_pkg::jse_in_t  item,
  output logic              res_valid,
  input  logic              res_ready,
  output jse_pkg::jse_out_t res
);

  jse_pkg::jse_seq_t seq;

  jse_expand u_expand (
    .item (item),
    .seq  (seq)
  );

  jse_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .seq_valid (item_valid),
    .seq_ready (item_ready),
    .seq       (seq),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
